[src/ectdt_pkg.sv]
// Package for the exposure code to decimal text core.
// Holds field widths, reciprocal constants, ASCII codes and the format type.
// No dependencies.
package ectdt_pkg;

   // Field widths
   localparam int CODE_W   = 16;
   localparam int CHAR_W   = 6;
   localparam int MICROS_W = 21;
   localparam int RECIP_W  = 22;
   localparam int PROD_W   = MICROS_W + RECIP_W;
   localparam int VALUE_W  = 11;
   localparam int REM_W    = 10;
   localparam int DIGIT_W  = 4;

   // Exact reciprocals: x / D == (x * RECIP) >> SHIFT over each range used
   localparam logic [RECIP_W-1:0] RECIP_DIV10   = 22'd13108;    // shift 17, x < 10000
   localparam logic [RECIP_W-1:0] RECIP_DIV100  = 22'd167773;   // shift 24, x < 100000
   localparam logic [RECIP_W-1:0] RECIP_DIV1000 = 22'd2147484;  // shift 31, x < 2^21

   // Range limits in microseconds
   localparam logic [MICROS_W-1:0] LIMIT_10MS  = 21'd10000;
   localparam logic [MICROS_W-1:0] LIMIT_100MS = 21'd100000;

   // ASCII codes, masked to the character width
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_POINT = 6'd46;
   localparam logic [CHAR_W-1:0] ASCII_SPACE = 6'd32;

   // Display format chosen from the millisecond range
   typedef enum logic [1:0] {
      FMT_HUNDREDTHS,  // D.DD
      FMT_TENTHS,      // DD.D
      FMT_WHOLE        // DDDD, leading zeros blanked
   } fmt_type;

   // Turn a decimal digit into its ASCII character
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      return ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
   endfunction

endpackage

[src/exposure_code_to_decimal_text_core.sv]
// Exposure code to four-character decimal text, five-stage pipeline.
// busy is always low; the receiver cannot stall, so nothing ever holds the pipeline.
// Stages: microseconds and range, reciprocal multiply, shift and thousands digit,
// hundreds digit, tens and units digits with character formatting.
// Reset (synchronous, active high) clears only the stage valid bits.
module exposure_code_to_decimal_text_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ectdt_pkg::CODE_W-1:0]   req_exposure_code,
   output logic                           rsp_valid,
   output logic [ectdt_pkg::CHAR_W-1:0]   rsp_char_first,
   output logic [ectdt_pkg::CHAR_W-1:0]   rsp_char_second,
   output logic [ectdt_pkg::CHAR_W-1:0]   rsp_char_third,
   output logic [ectdt_pkg::CHAR_W-1:0]   rsp_char_fourth
);
   import ectdt_pkg::*;

   // Stage valid bits
   logic [4:0] vld_ff, vld_in;

   // Stage 1: microseconds and format
   logic [MICROS_W-1:0] micros_in, s1_micros_ff;
   fmt_type             fmt_in, s1_fmt_ff;

   // Stage 2: reciprocal product
   logic [PROD_W-1:0]   prod_in, s2_prod_ff;
   fmt_type             s2_fmt_ff;

   // Stage 3: scaled value split into thousands digit and remainder
   logic [VALUE_W-1:0]  value;
   logic                d0_in, s3_d0_ff;
   logic [REM_W-1:0]    rem_in, s3_rem_ff;
   fmt_type             s3_fmt_ff;

   // Stage 4: hundreds digit and remainder below 100
   logic [15:0]         hund_prod;
   logic [DIGIT_W-1:0]  d1_in, s4_d1_ff;
   logic [6:0]          r2_in, s4_r2_ff;
   logic                s4_d0_ff;
   fmt_type             s4_fmt_ff;

   // Stage 5: tens and units, characters
   logic [14:0]         tens_prod;
   logic [DIGIT_W-1:0]  d2, d3;
   logic [CHAR_W-1:0]   c0_in, c1_in, c2_in, c3_in;
   logic [CHAR_W-1:0]   c0_ff, c1_ff, c2_ff, c3_ff;

   assign busy = 1'b0;

   // Advance valid bits every cycle
   assign vld_in = {vld_ff[3:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: add coarse and fine steps, pick the format
   always_comb begin
      micros_in = {1'b0, req_exposure_code[7:0], 12'b0}
                + {9'b0, req_exposure_code[15:8], 4'b0};
      if (micros_in < LIMIT_10MS) begin
         fmt_in = FMT_HUNDREDTHS;
      end else if (micros_in < LIMIT_100MS) begin
         fmt_in = FMT_TENTHS;
      end else begin
         fmt_in = FMT_WHOLE;
      end
   end

   always_ff @(posedge clock) begin
      s1_micros_ff <= micros_in;
      s1_fmt_ff    <= fmt_in;
   end

   // Stage 2: multiply by the reciprocal of the chosen divisor
   always_comb begin
      case (s1_fmt_ff)
         FMT_HUNDREDTHS: prod_in = {{RECIP_W{1'b0}}, s1_micros_ff} * {{MICROS_W{1'b0}}, RECIP_DIV10};
         FMT_TENTHS:     prod_in = {{RECIP_W{1'b0}}, s1_micros_ff} * {{MICROS_W{1'b0}}, RECIP_DIV100};
         default:        prod_in = {{RECIP_W{1'b0}}, s1_micros_ff} * {{MICROS_W{1'b0}}, RECIP_DIV1000};
      endcase
   end

   always_ff @(posedge clock) begin
      s2_prod_ff <= prod_in;
      s2_fmt_ff  <= s1_fmt_ff;
   end

   // Stage 3: drop the fraction bits, split off the thousands digit
   always_comb begin
      case (s2_fmt_ff)
         FMT_HUNDREDTHS: value = {1'b0, s2_prod_ff[26:17]};
         FMT_TENTHS:     value = {1'b0, s2_prod_ff[33:24]};
         default:        value = s2_prod_ff[41:31];
      endcase
      d0_in  = (value >= 11'd1000);
      rem_in = d0_in ? REM_W'(value - 11'd1000) : value[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      s3_d0_ff  <= d0_in;
      s3_rem_ff <= rem_in;
      s3_fmt_ff <= s2_fmt_ff;
   end

   // Stage 4: hundreds digit as (rem * 41) >> 12, exact for rem < 1024
   always_comb begin
      hund_prod = {6'b0, s3_rem_ff} * 16'd41;
      d1_in     = hund_prod[15:12];
      r2_in     = 7'(s3_rem_ff - ({6'b0, d1_in} * 10'd100));
   end

   always_ff @(posedge clock) begin
      s4_d1_ff  <= d1_in;
      s4_r2_ff  <= r2_in;
      s4_d0_ff  <= s3_d0_ff;
      s4_fmt_ff <= s3_fmt_ff;
   end

   // Stage 5: tens as (r2 * 205) >> 11, then place digits, point and blanks
   always_comb begin
      tens_prod = {8'b0, s4_r2_ff} * 15'd205;
      d2        = tens_prod[14:11];
      d3        = 4'(s4_r2_ff - ({3'b0, d2} * 7'd10));
      case (s4_fmt_ff)
         FMT_HUNDREDTHS: begin
            c0_in = digit_char(s4_d1_ff);
            c1_in = ASCII_POINT;
            c2_in = digit_char(d2);
         end
         FMT_TENTHS: begin
            c0_in = digit_char(s4_d1_ff);
            c1_in = digit_char(d2);
            c2_in = ASCII_POINT;
         end
         default: begin
            c0_in = s4_d0_ff ? digit_char(4'd1) : ASCII_SPACE;
            c1_in = (!s4_d0_ff && s4_d1_ff == '0) ? ASCII_SPACE : digit_char(s4_d1_ff);
            c2_in = (!s4_d0_ff && s4_d1_ff == '0 && d2 == '0) ? ASCII_SPACE : digit_char(d2);
         end
      endcase
      c3_in = digit_char(d3);
   end

   always_ff @(posedge clock) begin
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      c3_ff <= c3_in;
   end

   // Drive the result ports from the last stage
   assign rsp_valid       = vld_ff[4];
   assign rsp_char_first  = c0_ff;
   assign rsp_char_second = c1_ff;
   assign rsp_char_third  = c2_ff;
   assign rsp_char_fourth = c3_ff;

endmodule
